// ===== design/otq_pkg.sv =====
// ============================================================================
// otq_pkg
// Shared widths, codes, sequencer states and inter-module structs for the
// ordered timer queue.
// ============================================================================
package otq_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int TIME_W        = 48;
    localparam int IVL_W         = 32;
    localparam int DLY_CFG_W     = 20;
    localparam int SLOT_OUT_W    = 6;

    localparam logic [DLY_CFG_W-1:0] MIN_ARM_DELAY_RST = DLY_CFG_W'(100);
    localparam logic [TIME_W-1:0]    TIME_MAX          = {TIME_W{1'b1}};

    // input opcode
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_EVAL,
        ST_RELOAD,
        ST_DLY_SUB,
        ST_DLY_CLAMP,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_FINAL
    } otq_state_t;

    // sequencer -> scan unit, aligned with the expiry read data
    typedef struct packed {
        logic clear;     // start a new pass
        logic valid;     // read data of one slot present
        logic use_ok;    // slot in use: counts for the minimum
        logic cand_ok;   // in use, not yet reported, check item
    } scan_ctl_t;

    // scan unit -> sequencer
    typedef struct packed {
        logic              any;
        logic [TIME_W-1:0] min_exp;
        logic              cand_found;
    } scan_res_t;

    // one result word
    typedef struct packed {
        logic [SLOT_OUT_W-1:0] timer_slot;
        logic                  expired_valid;
        logic                  rearm;
        logic [TIME_W-1:0]     arm_delay_us;
        logic [TIME_W-1:0]     next_expiry_us;
        logic                  queue_full;
        logic                  last;
    } otq_result_t;

endpackage

// ===== design/otq_slot_mem.sv =====
// ============================================================================
// otq_slot_mem
// Per-slot expiry and repeat interval storage, registered read.
// ============================================================================
module otq_slot_mem #(
    parameter int SLOTS  = otq_pkg::SLOTS_DEFAULT,
    parameter int SLOT_W = 4
) (
    input  logic                          clk,
    input  logic                          exp_we,
    input  logic                          ivl_we,
    input  logic [SLOT_W-1:0]             wr_addr,
    input  logic [otq_pkg::TIME_W-1:0]    exp_wdata,
    input  logic [otq_pkg::IVL_W-1:0]     ivl_wdata,
    input  logic                          exp_re,
    input  logic [SLOT_W-1:0]             exp_raddr,
    input  logic                          ivl_re,
    input  logic [SLOT_W-1:0]             ivl_raddr,
    output logic [otq_pkg::TIME_W-1:0]    exp_rdata,
    output logic [otq_pkg::IVL_W-1:0]     ivl_rdata
);

    logic [otq_pkg::TIME_W-1:0] exp_mem [SLOTS];
    logic [otq_pkg::IVL_W-1:0]  ivl_mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (exp_we)
        begin
            exp_mem[wr_addr] <= exp_wdata;
        end
        if (exp_re)
        begin
            exp_rdata <= exp_mem[exp_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ivl_we)
        begin
            ivl_mem[wr_addr] <= ivl_wdata;
        end
        if (ivl_re)
        begin
            ivl_rdata <= ivl_mem[ivl_raddr];
        end
    end

endmodule

// ===== design/otq_scan.sv =====
// ============================================================================
// otq_scan
// Running minimum and earliest-expired-candidate tracker, one slot per cycle.
// ============================================================================
module otq_scan #(
    parameter int SLOT_W = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  otq_pkg::scan_ctl_t         ctl,
    input  logic [SLOT_W-1:0]          slot,
    input  logic [otq_pkg::TIME_W-1:0] expiry,
    input  logic [otq_pkg::TIME_W-1:0] now,
    output otq_pkg::scan_res_t         res,
    output logic [SLOT_W-1:0]          cand_slot
);

    logic                       any_reg, any_next;
    logic [otq_pkg::TIME_W-1:0] min_reg, min_next;
    logic                       cfound_reg, cfound_next;
    logic [otq_pkg::TIME_W-1:0] cexp_reg, cexp_next;
    logic [SLOT_W-1:0]          cslot_reg, cslot_next;
    logic                       take_min;
    logic                       take_cand;

    // strict compares: ascending slot order keeps the lowest slot on ties
    always_comb
    begin
        take_min  = ctl.valid && ctl.use_ok && (!any_reg || (expiry < min_reg));
        take_cand = ctl.valid && ctl.cand_ok && (expiry <= now)
                    && (!cfound_reg || (expiry < cexp_reg));

        any_next    = any_reg;
        min_next    = min_reg;
        cfound_next = cfound_reg;
        cexp_next   = cexp_reg;
        cslot_next  = cslot_reg;
        if (ctl.clear)
        begin
            any_next    = 1'b0;
            cfound_next = 1'b0;
        end
        else
        begin
            if (take_min)
            begin
                any_next = 1'b1;
                min_next = expiry;
            end
            if (take_cand)
            begin
                cfound_next = 1'b1;
                cexp_next   = expiry;
                cslot_next  = slot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg    <= 1'b0;
            cfound_reg <= 1'b0;
        end
        else
        begin
            any_reg    <= any_next;
            cfound_reg <= cfound_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg   <= min_next;
        cexp_reg  <= cexp_next;
        cslot_reg <= cslot_next;
    end

    assign res.any        = any_reg;
    assign res.min_exp    = min_reg;
    assign res.cand_found = cfound_reg;
    assign cand_slot      = cslot_reg;

endmodule

// ===== design/otq_ctrl.sv =====
// ============================================================================
// otq_ctrl
// Sequencer: slot scans, add/reload writes, expired order list, arm delay.
// ============================================================================
module otq_ctrl #(
    parameter int SLOTS  = otq_pkg::SLOTS_DEFAULT,
    parameter int SLOT_W = 4,
    parameter int CNT_W  = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input item
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [otq_pkg::TIME_W-1:0]    now_us,
    input  logic [otq_pkg::TIME_W-1:0]    when_us,
    input  logic [otq_pkg::IVL_W-1:0]     interval_us,
    input  logic [otq_pkg::DLY_CFG_W-1:0] min_delay,
    // result word
    input  logic                          out_free,
    output logic                          out_load,
    output otq_pkg::otq_result_t          out_res,
    // slot memory
    output logic                          exp_we,
    output logic                          ivl_we,
    output logic [SLOT_W-1:0]             wr_addr,
    output logic [otq_pkg::TIME_W-1:0]    exp_wdata,
    output logic [otq_pkg::IVL_W-1:0]     ivl_wdata,
    output logic                          exp_re,
    output logic [SLOT_W-1:0]             exp_raddr,
    output logic                          ivl_re,
    output logic [SLOT_W-1:0]             ivl_raddr,
    input  logic [otq_pkg::IVL_W-1:0]     ivl_rdata,
    // scan unit
    output otq_pkg::scan_ctl_t            scan_ctl,
    output logic [SLOT_W-1:0]             scan_slot,
    output logic [otq_pkg::TIME_W-1:0]    scan_now,
    input  otq_pkg::scan_res_t            scan_res,
    input  logic [SLOT_W-1:0]             cand_slot
);

    localparam logic [SLOT_W-1:0] LAST_SLOT    = SLOT_W'(SLOTS - 1);
    localparam int                TW           = otq_pkg::TIME_W;
    localparam int                SLOT_OUT_W_L = otq_pkg::SLOT_OUT_W;

    otq_pkg::otq_state_t state_reg, state_next;

    logic                  func_reg, func_next;
    logic [TW-1:0]         now_reg, now_next;
    logic [TW-1:0]         when_reg, when_next;
    logic [otq_pkg::IVL_W-1:0] ivl_reg, ivl_next;
    logic [SLOTS-1:0]      in_use_reg, in_use_next;
    logic [SLOTS-1:0]      done_reg, done_next;
    logic [SLOT_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                  scan_vld_reg, scan_vld_next;
    logic [SLOT_W-1:0]     scan_slot_reg, scan_slot_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [SLOT_W-1:0]     k_reg, k_next;
    logic                  rearm_reg, rearm_next;
    logic                  full_reg, full_next;
    logic [SLOT_OUT_W_L-1:0] fslot_reg, fslot_next;
    logic [TW-1:0]         next_reg, next_nx;
    logic [TW-1:0]         tgt_reg, tgt_next;
    logic [TW:0]           diff_reg, diff_next;
    logic [TW-1:0]         delay_reg, delay_next;

    // expired order list
    logic [SLOT_W-1:0]     order_mem [SLOTS];
    logic [SLOT_W-1:0]     order_rd_reg;
    logic                  order_we;

    logic                  free_found;
    logic [SLOT_W-1:0]     free_slot;
    logic                  changed;
    logic                  k_last;
    logic [TW:0]           reload_sum;
    logic [TW-1:0]         reload_exp;
    logic [TW-1:0]         dpos;
    logic [TW-1:0]         mind;
    logic [TW-1:0]         clamped;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    assign changed    = !scan_res.any || (when_reg < scan_res.min_exp);
    assign k_last     = ((CNT_W'(k_reg) + CNT_W'(1)) == n_reg);
    assign reload_sum = {1'b0, now_reg} + {{(TW + 1 - otq_pkg::IVL_W){1'b0}}, ivl_rdata};
    assign reload_exp = reload_sum[TW] ? otq_pkg::TIME_MAX : reload_sum[TW-1:0];
    assign dpos       = diff_reg[TW] ? '0 : diff_reg[TW-1:0];
    assign mind       = TW'(min_delay);
    assign clamped    = (dpos < mind) ? mind : dpos;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            otq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = otq_pkg::ST_SCAN;
                end
            end
            otq_pkg::ST_SCAN:
            begin
                if (scan_cnt_reg == LAST_SLOT)
                begin
                    state_next = otq_pkg::ST_SCAN_LAST;
                end
            end
            otq_pkg::ST_SCAN_LAST:
            begin
                state_next = otq_pkg::ST_EVAL;
            end
            otq_pkg::ST_EVAL:
            begin
                if ((func_reg == otq_pkg::FUNC_CHECK) && scan_res.cand_found)
                begin
                    state_next = otq_pkg::ST_RELOAD;
                end
                else
                begin
                    state_next = otq_pkg::ST_DLY_SUB;
                end
            end
            otq_pkg::ST_RELOAD:
            begin
                state_next = otq_pkg::ST_SCAN;
            end
            otq_pkg::ST_DLY_SUB:
            begin
                state_next = otq_pkg::ST_DLY_CLAMP;
            end
            otq_pkg::ST_DLY_CLAMP:
            begin
                if (n_reg != '0)
                begin
                    state_next = otq_pkg::ST_EMIT_RD;
                end
                else
                begin
                    state_next = otq_pkg::ST_FINAL;
                end
            end
            otq_pkg::ST_EMIT_RD:
            begin
                state_next = otq_pkg::ST_EMIT_OUT;
            end
            otq_pkg::ST_EMIT_OUT:
            begin
                if (out_free)
                begin
                    state_next = k_last ? otq_pkg::ST_FINAL : otq_pkg::ST_EMIT_RD;
                end
            end
            otq_pkg::ST_FINAL:
            begin
                if (out_free)
                begin
                    state_next = otq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = otq_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_ready  = 1'b0;
        out_load  = 1'b0;
        out_res   = '0;
        exp_we    = 1'b0;
        ivl_we    = 1'b0;
        wr_addr   = free_slot;
        exp_wdata = when_reg;
        ivl_wdata = ivl_reg;
        exp_re    = 1'b0;
        exp_raddr = scan_cnt_reg;
        ivl_re    = 1'b0;
        ivl_raddr = cand_slot;
        order_we  = 1'b0;
        scan_ctl  = '0;

        func_next      = func_reg;
        now_next       = now_reg;
        when_next      = when_reg;
        ivl_next       = ivl_reg;
        in_use_next    = in_use_reg;
        done_next      = done_reg;
        scan_cnt_next  = scan_cnt_reg;
        scan_vld_next  = 1'b0;
        scan_slot_next = scan_cnt_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        rearm_next     = rearm_reg;
        full_next      = full_reg;
        fslot_next     = fslot_reg;
        next_nx        = next_reg;
        tgt_next       = tgt_reg;
        diff_next      = diff_reg;
        delay_next     = delay_reg;

        // read data of the slot issued last cycle
        scan_ctl.valid   = scan_vld_reg;
        scan_ctl.use_ok  = in_use_reg[scan_slot_reg];
        scan_ctl.cand_ok = in_use_reg[scan_slot_reg] && !done_reg[scan_slot_reg]
                           && (func_reg == otq_pkg::FUNC_CHECK);

        case (state_reg)
            otq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    func_next      = func;
                    now_next       = now_us;
                    when_next      = when_us;
                    ivl_next       = interval_us;
                    done_next      = '0;
                    n_next         = '0;
                    k_next         = '0;
                    scan_cnt_next  = '0;
                    scan_ctl.clear = 1'b1;
                end
            end
            otq_pkg::ST_SCAN:
            begin
                exp_re        = 1'b1;
                scan_vld_next = 1'b1;
                scan_cnt_next = scan_cnt_reg + SLOT_W'(1);
            end
            otq_pkg::ST_SCAN_LAST:
            begin
                scan_cnt_next = '0;
            end
            otq_pkg::ST_EVAL:
            begin
                full_next  = 1'b0;
                fslot_next = '0;
                if (func_reg == otq_pkg::FUNC_ADD)
                begin
                    if (!free_found)
                    begin
                        full_next  = 1'b1;
                        rearm_next = 1'b0;
                        next_nx    = scan_res.any ? scan_res.min_exp : '0;
                        tgt_next   = now_reg;
                    end
                    else
                    begin
                        exp_we                 = 1'b1;
                        ivl_we                 = 1'b1;
                        in_use_next[free_slot] = 1'b1;
                        fslot_next             = SLOT_OUT_W_L'(free_slot);
                        rearm_next             = changed;
                        next_nx                = changed ? when_reg : scan_res.min_exp;
                        tgt_next               = when_reg;
                    end
                end
                else if (scan_res.cand_found)
                begin
                    order_we             = 1'b1;
                    n_next               = n_reg + CNT_W'(1);
                    done_next[cand_slot] = 1'b1;
                    ivl_re               = 1'b1;
                end
                else
                begin
                    // final pass: no expired slot left, minimum is post-step
                    rearm_next = scan_res.any;
                    next_nx    = scan_res.any ? scan_res.min_exp : '0;
                    tgt_next   = scan_res.min_exp;
                end
            end
            otq_pkg::ST_RELOAD:
            begin
                wr_addr        = cand_slot;
                exp_wdata      = reload_exp;
                scan_ctl.clear = 1'b1;
                if (ivl_rdata != '0)
                begin
                    exp_we = 1'b1;
                end
                else
                begin
                    in_use_next[cand_slot] = 1'b0;
                end
            end
            otq_pkg::ST_DLY_SUB:
            begin
                diff_next = {1'b0, tgt_reg} - {1'b0, now_reg};
            end
            otq_pkg::ST_DLY_CLAMP:
            begin
                delay_next = rearm_reg ? clamped : '0;
            end
            otq_pkg::ST_EMIT_RD:
            begin
            end
            otq_pkg::ST_EMIT_OUT:
            begin
                out_res.timer_slot     = SLOT_OUT_W_L'(order_rd_reg);
                out_res.expired_valid  = 1'b1;
                out_res.next_expiry_us = next_reg;
                if (out_free)
                begin
                    out_load = 1'b1;
                    k_next   = k_reg + SLOT_W'(1);
                end
            end
            otq_pkg::ST_FINAL:
            begin
                out_res.timer_slot     = fslot_reg;
                out_res.rearm          = rearm_reg;
                out_res.arm_delay_us   = delay_reg;
                out_res.next_expiry_us = next_reg;
                out_res.queue_full     = full_reg;
                out_res.last           = 1'b1;
                out_load               = out_free;
            end
            default:
            begin
            end
        endcase
    end

    assign scan_slot = scan_slot_reg;
    assign scan_now  = now_reg;

    always_ff @(posedge clk)
    begin
        if (order_we)
        begin
            order_mem[n_reg[SLOT_W-1:0]] <= cand_slot;
        end
        order_rd_reg <= order_mem[k_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= otq_pkg::ST_IDLE;
            in_use_reg   <= '0;
            done_reg     <= '0;
            scan_cnt_reg <= '0;
            scan_vld_reg <= 1'b0;
            n_reg        <= '0;
            k_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            in_use_reg   <= in_use_next;
            done_reg     <= done_next;
            scan_cnt_reg <= scan_cnt_next;
            scan_vld_reg <= scan_vld_next;
            n_reg        <= n_next;
            k_reg        <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        now_reg       <= now_next;
        when_reg      <= when_next;
        ivl_reg       <= ivl_next;
        scan_slot_reg <= scan_slot_next;
        rearm_reg     <= rearm_next;
        full_reg      <= full_next;
        fslot_reg     <= fslot_next;
        next_reg      <= next_nx;
        tgt_reg       <= tgt_next;
        diff_reg      <= diff_next;
        delay_reg     <= delay_next;
    end

endmodule

// ===== design/ordered_timer_queue.sv =====
// ============================================================================
// ordered_timer_queue
// Fixed-slot timer queue with one-shot and repeating timers. Reports expired
// timers in (expiry, slot) order and the hardware re-arm delay.
// ============================================================================
//
//  channel   handshake               payload
//  --------  ----------------------  ---------------------------------------
//  input     in_valid / in_ready     func, now_us, when_us, interval_us
//  output    out_valid / out_ready   timer_slot, expired_valid, rearm,
//                                    arm_delay_us, next_expiry_us,
//                                    queue_full, last
//  config    cfg_wr_en (no wait)     cfg_wr_data -> min_arm_delay
//
//  One word at a time. A pass reads every slot from the expiry memory, one
//  slot a cycle. Add: one pass, then the slot write when a slot is free,
//  the arm delay and the final word. Check with n expired timers: n + 1
//  passes (each expired timer costs one pass plus a reload step that writes
//  back its expiry or frees its slot), then the arm delay subtract and
//  clamp, an order list read per expired word, and the final word.
//  Reset clears the in-use bits and the sequencer; no clearing pass.
//  A stalled output holds the sequencer in place; the result register lets
//  the next word be formed while the previous one still waits.
//
module ordered_timer_queue #(
    parameter int TIMER_SLOTS = otq_pkg::SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input words
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [otq_pkg::TIME_W-1:0]    now_us,
    input  logic [otq_pkg::TIME_W-1:0]    when_us,
    input  logic [otq_pkg::IVL_W-1:0]     interval_us,
    // result words
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [otq_pkg::SLOT_OUT_W-1:0] timer_slot,
    output logic                          expired_valid,
    output logic                          rearm,
    output logic [otq_pkg::TIME_W-1:0]    arm_delay_us,
    output logic [otq_pkg::TIME_W-1:0]    next_expiry_us,
    output logic                          queue_full,
    output logic                          last,
    // min_arm_delay register
    input  logic                          cfg_wr_en,
    input  logic [otq_pkg::DLY_CFG_W-1:0] cfg_wr_data
);

    // slot index width; one slot still needs one address bit
    localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    // expired count goes up to TIMER_SLOTS
    localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);

    logic [otq_pkg::DLY_CFG_W-1:0] min_delay_reg, min_delay_next;
    logic                          out_valid_reg, out_valid_next;
    otq_pkg::otq_result_t          out_word_reg, out_word_next;

    logic                          out_free;
    logic                          out_load;
    otq_pkg::otq_result_t          out_res;

    logic                          exp_we;
    logic                          ivl_we;
    logic [SLOT_W-1:0]             wr_addr;
    logic [otq_pkg::TIME_W-1:0]    exp_wdata;
    logic [otq_pkg::IVL_W-1:0]     ivl_wdata;
    logic                          exp_re;
    logic [SLOT_W-1:0]             exp_raddr;
    logic                          ivl_re;
    logic [SLOT_W-1:0]             ivl_raddr;
    logic [otq_pkg::TIME_W-1:0]    exp_rdata;
    logic [otq_pkg::IVL_W-1:0]     ivl_rdata;

    otq_pkg::scan_ctl_t            scan_ctl;
    otq_pkg::scan_res_t            scan_res;
    logic [SLOT_W-1:0]             scan_slot;
    logic [otq_pkg::TIME_W-1:0]    scan_now;
    logic [SLOT_W-1:0]             cand_slot;

    // result register: free when empty or being taken this cycle
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        min_delay_next = cfg_wr_en ? cfg_wr_data : min_delay_reg;
        out_valid_next = out_load || (out_valid_reg && !out_ready);
        out_word_next  = out_load ? out_res : out_word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_delay_reg <= otq_pkg::MIN_ARM_DELAY_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            min_delay_reg <= min_delay_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    otq_slot_mem #(
        .SLOTS  (TIMER_SLOTS),
        .SLOT_W (SLOT_W)
    ) u_mem (
        .clk       (clk),
        .exp_we    (exp_we),
        .ivl_we    (ivl_we),
        .wr_addr   (wr_addr),
        .exp_wdata (exp_wdata),
        .ivl_wdata (ivl_wdata),
        .exp_re    (exp_re),
        .exp_raddr (exp_raddr),
        .ivl_re    (ivl_re),
        .ivl_raddr (ivl_raddr),
        .exp_rdata (exp_rdata),
        .ivl_rdata (ivl_rdata)
    );

    otq_scan #(
        .SLOT_W (SLOT_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .slot      (scan_slot),
        .expiry    (exp_rdata),
        .now       (scan_now),
        .res       (scan_res),
        .cand_slot (cand_slot)
    );

    otq_ctrl #(
        .SLOTS  (TIMER_SLOTS),
        .SLOT_W (SLOT_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .now_us      (now_us),
        .when_us     (when_us),
        .interval_us (interval_us),
        .min_delay   (min_delay_reg),
        .out_free    (out_free),
        .out_load    (out_load),
        .out_res     (out_res),
        .exp_we      (exp_we),
        .ivl_we      (ivl_we),
        .wr_addr     (wr_addr),
        .exp_wdata   (exp_wdata),
        .ivl_wdata   (ivl_wdata),
        .exp_re      (exp_re),
        .exp_raddr   (exp_raddr),
        .ivl_re      (ivl_re),
        .ivl_raddr   (ivl_raddr),
        .ivl_rdata   (ivl_rdata),
        .scan_ctl    (scan_ctl),
        .scan_slot   (scan_slot),
        .scan_now    (scan_now),
        .scan_res    (scan_res),
        .cand_slot   (cand_slot)
    );

    assign out_valid      = out_valid_reg;
    assign timer_slot     = out_word_reg.timer_slot;
    assign expired_valid  = out_word_reg.expired_valid;
    assign rearm          = out_word_reg.rearm;
    assign arm_delay_us   = out_word_reg.arm_delay_us;
    assign next_expiry_us = out_word_reg.next_expiry_us;
    assign queue_full     = out_word_reg.queue_full;
    assign last           = out_word_reg.last;

endmodule

// ===== design/otq_checker.sv =====
// ============================================================================
// otq_checker
// Port-level checks on the ordered timer queue, bound to the top level.
// ============================================================================
module otq_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           expired_valid,
    input logic                           rearm,
    input logic [otq_pkg::TIME_W-1:0]     arm_delay_us,
    input logic                           queue_full,
    input logic                           last
);

    // one word in flight: no second accept right after the first
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a word is being worked on");

    // an expired word is never the final word of its input
    a_expired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(expired_valid && last))
        else $error("expired word flagged as last");

    // a dropped add reports only itself
    a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && queue_full) |-> (last && !rearm && !expired_valid))
        else $error("queue_full word with other flags set");

    // delay is only reported with a re-arm request
    a_delay_needs_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !rearm) |-> (arm_delay_us == '0))
        else $error("arm delay without rearm");

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(last)))
        else $error("result word dropped while stalled");

endmodule

bind ordered_timer_queue otq_checker u_otq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .expired_valid (expired_valid),
    .rearm         (rearm),
    .arm_delay_us  (arm_delay_us),
    .queue_full    (queue_full),
    .last          (last)
);
